// ----- rtl/asd_pkg.sv -----
// ----------------------------------------------------------------------------
// asd_pkg
// Shared constants for the accelerometer step detector: parameter defaults,
// register indexes, register reset values and result field layout.
// ----------------------------------------------------------------------------
package asd_pkg;

  // Parameter defaults
  localparam int unsigned LONG_WINDOW_DEF  = 16;
  localparam int unsigned SHORT_WINDOW_DEF = 4;
  localparam int unsigned SAMPLE_BITS_DEF  = 8;

  // Register file
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_TOL  = 2'd3;

  localparam int unsigned VAL_W    = 9;   // threshold, peak, magnitude field
  localparam int unsigned MARGIN_W = 8;
  localparam int unsigned WIN_W    = 8;
  localparam int unsigned TOL_W    = 7;
  localparam int unsigned STEP_W   = 24;

  localparam logic [VAL_W-1:0]    BASE_THR_RST = 9'd155;
  localparam logic [MARGIN_W-1:0] MARGIN_RST   = 8'd15;
  localparam logic [WIN_W-1:0]    WIN_LEN_RST  = 8'd100;
  localparam logic [TOL_W-1:0]    POS_TOL_RST  = 7'd3;
  localparam logic [VAL_W-1:0]    PEAK_RST     = 9'd170;

  localparam logic [VAL_W-1:0]  VAL_MAX  = 9'd511;
  localparam logic [STEP_W-1:0] STEP_MAX = 24'hFF_FFFF;

  // Result layout in m_axis_tdata
  localparam int unsigned OUT_STEP_LSB = 0;
  localparam int unsigned OUT_DET_BIT  = 24;
  localparam int unsigned OUT_MAG_LSB  = 25;
  localparam int unsigned OUT_PEAK_LSB = 34;
  localparam int unsigned OUT_THR_LSB  = 43;
  localparam int unsigned OUT_MOV_BIT  = 52;
  localparam int unsigned OUT_W        = 56;

endpackage

// ----- rtl/accel_step_detector.sv -----
// ----------------------------------------------------------------------------
// accel_step_detector
// Step counter fed with three-axis acceleration samples; one status result
// per sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per request (x, y, z). m_axis returns one result
//   per sample: step count, step flag, magnitude, window peak, threshold and
//   the moving state. cfg_we_i/cfg_idx_i/cfg_data_i write the four control
//   registers; write them only while no sample is in flight.
// Sequence:
//   After acceptance a sample first fetches the evicted history entries from
//   the sample memory, then forms the means and squares (one reciprocal
//   multiplier shared by both means, four steps per axis), then runs the
//   bit-serial square root, then rounds the root and updates the state.
//   The result is loaded onto m_axis with the update, and the next sample
//   is accepted the cycle after, so a new sample is not taken before the
//   last one is through.
// Reset:
//   History reads as zero (per-entry valid bits), sums clear, registers take
//   their defaults and the detector starts paused with a zero step count.
// Backpressure:
//   A new sample is taken while the last result still waits on m_axis; the
//   state update and the result load hold until the output register frees.
// ----------------------------------------------------------------------------
module accel_step_detector #(
  parameter int unsigned LONG_WINDOW  = asd_pkg::LONG_WINDOW_DEF,
  parameter int unsigned SHORT_WINDOW = asd_pkg::SHORT_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS  = asd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // sample request: accel_x, accel_y, accel_z from bit 0 up, zero padded
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
  // result: step_count, step_detected, magnitude, window_peak, threshold,
  // moving from bit 0 up, zero padded
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  output logic [asd_pkg::OUT_W-1:0]                 m_axis_tdata,
  // register writes
  input  logic                                      cfg_we_i,
  input  logic [asd_pkg::CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [asd_pkg::CFG_DATA_W-1:0]            cfg_data_i
);
  import asd_pkg::*;

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned PTR_W  = $clog2(LONG_WINDOW);
  localparam int unsigned SUM_W  = SB + $clog2(LONG_WINDOW) + 1;  // signed running sum
  localparam int unsigned AW     = SUM_W + 1;                     // rounded sum magnitude
  localparam int unsigned KS     = AW + $clog2(SHORT_WINDOW);
  localparam int unsigned KL     = AW + $clog2(LONG_WINDOW);
  localparam int unsigned M_W    = AW + 1;
  localparam longint unsigned MS = ((64'd1 << KS) + SHORT_WINDOW - 1) / SHORT_WINDOW;
  localparam longint unsigned ML = ((64'd1 << KL) + LONG_WINDOW - 1) / LONG_WINDOW;
  localparam int unsigned P_W    = AW + M_W;
  localparam int unsigned MEAN_W = SB + 1;
  localparam int unsigned SQ_W   = 2 * MEAN_W;
  localparam int unsigned R_W    = SB + 2;                        // root / magnitude
  localparam int unsigned ACC_W  = 2 * R_W;
  localparam int unsigned REM_W  = R_W + 2;
  localparam int unsigned CNT_W  = $clog2(R_W + 1);

  localparam logic [AW-1:0]  HALF_S = AW'(SHORT_WINDOW / 2);
  localparam logic [AW-1:0]  HALF_L = AW'(LONG_WINDOW / 2);
  localparam logic [M_W-1:0] MUL_S  = M_W'(MS);
  localparam logic [M_W-1:0] MUL_L  = M_W'(ML);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD,
    ST_UPD,
    ST_AXIS,
    ST_SQRT,
    ST_ROUND,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    PH_SHORT,
    PH_LONG,
    PH_SQUARE,
    PH_ACC
  } phase_e;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                   state_q;
  phase_e                   ph_q;
  logic [1:0]               ax_q;
  logic [SB-1:0]            smp_q   [3];
  logic [SB-1:0]            old_q   [3];
  logic [SB-1:0]            snap_q  [3];
  logic signed [SUM_W-1:0]  lsum_q  [3];
  logic signed [SUM_W-1:0]  ssum_q  [3];
  logic [PTR_W-1:0]         ptr_q;
  logic [LONG_WINDOW-1:0]   vld_q;
  logic                     rvld_q;
  logic [3*SB-1:0]          rdata_q;
  logic signed [MEAN_W-1:0] mean_s_q;
  logic signed [MEAN_W-1:0] mean_l_q;
  logic [SQ_W-1:0]          sq_q;
  logic [ACC_W-1:0]         acc_q;
  logic [REM_W-1:0]         rem_q;
  logic [R_W-1:0]           root_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [R_W-1:0]           mag_q;
  logic [VAL_W-1:0]         peak_q;
  logic [VAL_W-1:0]         thr_q;
  logic [WIN_W-1:0]         wcnt_q;
  logic                     moving_q;
  logic [STEP_W-1:0]        steps_q;
  logic                     m_valid_q;
  logic [OUT_W-1:0]         m_data_q;

  logic [VAL_W-1:0]         base_q;
  logic [MARGIN_W-1:0]      margin_q;
  logic [WIN_W-1:0]         winlen_q;
  logic [TOL_W-1:0]         tol_q;

  // History memory: one word holds x, y, z of one sample.
  logic [3*SB-1:0]          hist_mem [LONG_WINDOW];

  // --------------------------------------------------------------------------
  // Register writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_THR_RST;
      margin_q <= MARGIN_RST;
      winlen_q <= WIN_LEN_RST;
      tol_q    <= POS_TOL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE_THR: base_q   <= cfg_data_i[VAL_W-1:0];
        REG_MARGIN:   margin_q <= cfg_data_i[MARGIN_W-1:0];
        REG_WIN_LEN:  winlen_q <= cfg_data_i[WIN_W-1:0];
        REG_POS_TOL:  tol_q    <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // History memory access
  // ptr_q points at the oldest entry, which the new sample overwrites. The
  // entry SHORT_WINDOW places behind it leaves the short window.
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0] short_addr;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] ptr_next;
  logic             mem_we;
  logic [3*SB-1:0]  mem_wdata;

  always_comb begin
    if (ptr_q >= PTR_W'(SHORT_WINDOW)) begin
      short_addr = ptr_q - PTR_W'(SHORT_WINDOW);
    end else begin
      short_addr = ptr_q + PTR_W'(LONG_WINDOW - SHORT_WINDOW);
    end
    rd_addr   = (state_q == ST_IDLE) ? ptr_q : short_addr;
    ptr_next  = (ptr_q == PTR_W'(LONG_WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
    mem_we    = (state_q == ST_UPD);
    mem_wdata = {smp_q[2], smp_q[1], smp_q[0]};
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= hist_mem[rd_addr];
    if (mem_we) begin
      hist_mem[ptr_q] <= mem_wdata;
    end
  end

  // Entries never written read as zero.
  logic [SB-1:0] rd_smp [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_smp[k] = rvld_q ? rdata_q[k*SB +: SB] : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Rounded mean, shared between the short and long window:
  // (sum + num/2) / num truncated toward zero, by reciprocal multiply on the
  // magnitude.
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0]  sum_sel;
  logic [AW-1:0]            rnd_sum;
  logic                     rnd_neg;
  logic [AW-1:0]            rnd_mag;
  logic [P_W-1:0]           prod;
  logic [MEAN_W-1:0]        quot;
  logic signed [MEAN_W-1:0] mean_val;

  always_comb begin
    sum_sel  = (ph_q == PH_SHORT) ? ssum_q[ax_q] : lsum_q[ax_q];
    rnd_sum  = {sum_sel[SUM_W-1], sum_sel} + ((ph_q == PH_SHORT) ? HALF_S : HALF_L);
    rnd_neg  = rnd_sum[AW-1];
    rnd_mag  = rnd_neg ? (~rnd_sum + AW'(1)) : rnd_sum;
    prod     = P_W'(rnd_mag) * P_W'((ph_q == PH_SHORT) ? MUL_S : MUL_L);
    quot     = (ph_q == PH_SHORT) ? MEAN_W'(prod >> KS) : MEAN_W'(prod >> KL);
    mean_val = rnd_neg ? -$signed(quot) : $signed(quot);
  end

  // Squared difference of the two means
  logic signed [MEAN_W:0] diff;
  logic [MEAN_W-1:0]      diff_abs;
  always_comb begin
    diff     = {mean_s_q[MEAN_W-1], mean_s_q} - {mean_l_q[MEAN_W-1], mean_l_q};
    diff_abs = diff[MEAN_W] ? MEAN_W'(-diff) : MEAN_W'(diff);
  end

  // One square-root digit a cycle
  logic [REM_W-1:0] sq_rem;
  logic [REM_W-1:0] sq_trial;
  always_comb begin
    sq_rem   = {rem_q[REM_W-3:0], acc_q[ACC_W-1 -: 2]};
    sq_trial = {root_q, 2'b01};
  end

  // --------------------------------------------------------------------------
  // Window peak, threshold and step decision for the finishing sample
  // --------------------------------------------------------------------------
  logic [VAL_W-1:0]  mag_sat;
  logic [VAL_W-1:0]  peak_raised;
  logic [VAL_W:0]    peak_rst_sum;
  logic [VAL_W-1:0]  peak_rst_val;
  logic [WIN_W-1:0]  wcnt_inc;
  logic              win_end;
  logic [VAL_W-1:0]  thr_new;
  logic [VAL_W-1:0]  peak_new;
  logic [WIN_W-1:0]  wcnt_new;
  logic              below;
  logic [SB:0]       tol_hi;
  logic [SB-1:0]     dlt [3];
  logic [2:0]        near;
  logic              go_paused;
  logic              go_moving;
  logic              step_ok;
  logic [STEP_W-1:0] steps_new;
  logic              out_free;
  logic              m_load;
  logic [OUT_W-1:0]  res_word;

  always_comb begin
    mag_sat      = (mag_q > R_W'(VAL_MAX)) ? VAL_MAX : mag_q[VAL_W-1:0];
    peak_raised  = (mag_q > R_W'(peak_q)) ? mag_sat : peak_q;
    peak_rst_sum = {1'b0, base_q} + (VAL_W+1)'(margin_q);
    peak_rst_val = peak_rst_sum[VAL_W] ? VAL_MAX : peak_rst_sum[VAL_W-1:0];
    wcnt_inc     = wcnt_q + WIN_W'(1);
    win_end      = (wcnt_inc == winlen_q);
    if (win_end) begin
      thr_new  = (peak_raised > VAL_W'(margin_q)) ? peak_raised - VAL_W'(margin_q) : '0;
      peak_new = peak_rst_val;
      wcnt_new = '0;
    end else begin
      thr_new  = thr_q;
      peak_new = peak_raised;
      wcnt_new = wcnt_inc;
    end
    below  = (mag_q < R_W'(thr_new));
    tol_hi = {1'b1, {SB{1'b0}}} - (SB+1)'(tol_q);
    // distance from the snapshot wraps at the sample width
    for (int k = 0; k < 3; k++) begin
      dlt[k]  = smp_q[k] - snap_q[k];
      near[k] = ({1'b0, dlt[k]} <= (SB+1)'(tol_q)) || ({1'b0, dlt[k]} >= tol_hi);
    end
    go_paused = moving_q && below;
    go_moving = !moving_q && !below;
    step_ok   = go_paused && (&near);
    steps_new = (step_ok && (steps_q != STEP_MAX)) ? steps_q + STEP_W'(1) : steps_q;
    out_free  = !m_valid_q || m_axis_tready;
    m_load    = (state_q == ST_FINISH) && out_free;
    res_word  = '0;
    res_word[OUT_STEP_LSB +: STEP_W] = steps_new;
    res_word[OUT_DET_BIT]            = step_ok;
    res_word[OUT_MAG_LSB +: VAL_W]   = mag_q[VAL_W-1:0];
    res_word[OUT_PEAK_LSB +: VAL_W]  = peak_new;
    res_word[OUT_THR_LSB +: VAL_W]   = thr_new;
    res_word[OUT_MOV_BIT]            = go_moving || (moving_q && !go_paused);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ph_q      <= PH_SHORT;
      ax_q      <= '0;
      for (int k = 0; k < 3; k++) begin
        smp_q[k]  <= '0;
        old_q[k]  <= '0;
        snap_q[k] <= '0;
        lsum_q[k] <= '0;
        ssum_q[k] <= '0;
      end
      ptr_q     <= '0;
      vld_q     <= '0;
      rvld_q    <= 1'b0;
      mean_s_q  <= '0;
      mean_l_q  <= '0;
      sq_q      <= '0;
      acc_q     <= '0;
      rem_q     <= '0;
      root_q    <= '0;
      cnt_q     <= '0;
      mag_q     <= '0;
      peak_q    <= PEAK_RST;
      thr_q     <= BASE_THR_RST;
      wcnt_q    <= '0;
      moving_q  <= 1'b0;
      steps_q   <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      rvld_q <= vld_q[rd_addr];
      // load a new result, or drop the one the receiver takes
      if (m_load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= res_word;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          // oldest entry is being read this cycle
          if (s_axis_tvalid) begin
            for (int k = 0; k < 3; k++) begin
              smp_q[k] <= s_axis_tdata[k*SB +: SB];
            end
            state_q <= ST_OLD;
          end
        end

        ST_OLD: begin
          for (int k = 0; k < 3; k++) begin
            old_q[k] <= rd_smp[k];
          end
          state_q <= ST_UPD;
        end

        ST_UPD: begin
          // rd_smp now holds the entry leaving the short window
          for (int k = 0; k < 3; k++) begin
            lsum_q[k] <= lsum_q[k] + SUM_W'($signed(smp_q[k])) - SUM_W'($signed(old_q[k]));
            ssum_q[k] <= ssum_q[k] + SUM_W'($signed(smp_q[k])) - SUM_W'($signed(rd_smp[k]));
          end
          vld_q[ptr_q] <= 1'b1;
          ptr_q        <= ptr_next;
          ax_q         <= '0;
          ph_q         <= PH_SHORT;
          acc_q        <= '0;
          state_q      <= ST_AXIS;
        end

        ST_AXIS: begin
          unique case (ph_q)
            PH_SHORT: begin
              mean_s_q <= mean_val;
              ph_q     <= PH_LONG;
            end
            PH_LONG: begin
              mean_l_q <= mean_val;
              ph_q     <= PH_SQUARE;
            end
            PH_SQUARE: begin
              sq_q <= SQ_W'(diff_abs) * SQ_W'(diff_abs);
              ph_q <= PH_ACC;
            end
            PH_ACC: begin
              acc_q <= acc_q + ACC_W'(sq_q);
              ph_q  <= PH_SHORT;
              if (ax_q == 2'd2) begin
                rem_q   <= '0;
                root_q  <= '0;
                cnt_q   <= CNT_W'(R_W);
                state_q <= ST_SQRT;
              end else begin
                ax_q <= ax_q + 2'd1;
              end
            end
            default: ph_q <= PH_SHORT;
          endcase
        end

        ST_SQRT: begin
          if (sq_rem >= sq_trial) begin
            rem_q  <= sq_rem - sq_trial;
            root_q <= {root_q[R_W-2:0], 1'b1};
          end else begin
            rem_q  <= sq_rem;
            root_q <= {root_q[R_W-2:0], 1'b0};
          end
          acc_q <= acc_q << 2;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_ROUND;
          end
        end

        ST_ROUND: begin
          // round to nearest: bump when the remainder exceeds the root
          mag_q   <= (rem_q > REM_W'(root_q)) ? root_q + R_W'(1) : root_q;
          state_q <= ST_FINISH;
        end

        ST_FINISH: begin
          // hold the update until the output register can take the result
          if (out_free) begin
            peak_q   <= peak_new;
            thr_q    <= thr_new;
            wcnt_q   <= wcnt_new;
            steps_q  <= steps_new;
            if (go_paused) begin
              moving_q <= 1'b0;
            end else if (go_moving) begin
              moving_q <= 1'b1;
              for (int k = 0; k < 3; k++) begin
                snap_q[k] <= smp_q[k];
              end
            end
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_load_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FINISH))
    else $error("result loaded outside the finishing step");

  a_step_ends_moving : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[OUT_DET_BIT]) |-> !m_axis_tdata[OUT_MOV_BIT])
    else $error("step reported while still moving");

  a_ptr_only_on_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_UPD) |=> $stable(ptr_q))
    else $error("history pointer moved outside the update step");

  a_ptr_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q < PTR_W'(LONG_WINDOW - 1) || ptr_q == PTR_W'(LONG_WINDOW - 1))
    else $error("history pointer beyond the window");

endmodule
